@@ hdl/sha_pkg.sv @@
// SHA-256 hasher package: round constants, initial hash, helper functions.
// No dependencies.
`timescale 1ns / 1ps
package sha_pkg;
    localparam logic [31:0] K_TABLE [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] H_INIT [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    // one 512-bit block handed from the front to the compression core
    typedef struct packed {
        logic [511:0] blk;
        logic         fin;   // last block of the message
    } t_blk;

    typedef enum logic [1:0] {
        F_LOAD, F_PAD, F_PUSH
    } t_fstate;

    typedef enum logic [1:0] {
        B_IDLE, B_ROUND, B_ADD, B_OUT
    } t_bstate;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction
endpackage

@@ hdl/sha_front.sv @@
// Front end: packs bytes into 512-bit blocks, counts bits, applies padding.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_front import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    output logic        o_blk_valid,
    input  logic        i_blk_stall,
    output t_blk        o_blk
);
    t_fstate      r_state, n_state;
    logic [511:0] r_buf, n_buf;
    logic [5:0]   r_cnt, n_cnt;
    logic [63:0]  r_len, n_len;
    logic         r_fin, n_fin;   // padding still to be finished after a push
    logic         r_final, n_final;
    logic         acc;
    logic [511:0] pad_buf;
    // the 0x80 byte goes first in the next block only when the message
    // ended exactly on a block boundary
    logic         r_pad_first, n_pad_first;

    function automatic logic [511:0] put(input logic [511:0] b, input logic [5:0] p,
                                         input logic [7:0] v);
        logic [511:0] t;
        t = b;
        t[511 - 8 * p -: 8] = v;
        put = t;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_LOAD;
            r_cnt   <= '0;
            r_len   <= '0;
            r_fin   <= 1'b0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
            r_fin   <= n_fin;
            r_final <= n_final;
        end
        r_buf <= n_buf;
    end

    assign o_stall     = (r_state != F_LOAD);
    assign acc         = i_valid && !o_stall;
    assign o_blk_valid = (r_state == F_PUSH);
    assign o_blk.blk   = r_buf;
    assign o_blk.fin   = r_final;

    // zero every byte from the fill position on; F_PAD adds the length if it fits
    always_comb begin
        pad_buf = r_buf;
        for (int i = 0; i < 64; i++) begin
            if (6'(i) >= r_cnt) pad_buf[511 - 8 * i -: 8] = 8'h00;
        end
    end

    always_comb begin
        n_state = r_state;
        n_buf   = r_buf;
        n_cnt   = r_cnt;
        n_len   = r_len;
        n_fin   = r_fin;
        n_final = r_final;
        case (r_state)
            F_LOAD: begin
                if (acc) begin
                    if (i_byte_valid) begin
                        n_buf = put(r_buf, r_cnt, i_data_byte);
                        n_len = r_len + 64'd8;
                        n_cnt = r_cnt + 6'd1;
                    end
                    if (i_byte_valid && r_cnt == 6'd63) begin
                        n_state = F_PUSH;
                        n_final = 1'b0;
                        n_fin   = i_end_of_message;
                    end else if (i_end_of_message) begin
                        n_buf   = put(n_buf, n_cnt, PAD_BYTE);
                        n_cnt   = n_cnt + 6'd1;
                        n_state = F_PAD;
                    end
                end
            end
            F_PAD: begin
                // r_cnt == 0 here means the pad byte filled the block
                n_buf   = (r_cnt == 6'd0) ? r_buf : pad_buf;
                if (r_cnt != 6'd0 && r_cnt <= LEN_POS) begin
                    n_buf[63:0] = r_len;
                    n_final     = 1'b1;
                end else begin
                    n_final     = 1'b0;
                end
                n_state = F_PUSH;
                n_fin   = !n_final;
                n_cnt   = '0;
            end
            F_PUSH: begin
                if (!i_blk_stall) begin
                    if (r_fin) begin
                        n_state = F_PAD;
                        n_fin   = 1'b0;
                        n_cnt   = 6'd1;
                        n_buf   = put('0, 6'd0, r_pad_first ? PAD_BYTE : 8'h00);
                    end else begin
                        n_state = F_LOAD;
                        n_cnt   = '0;
                        if (r_final) n_len = '0;
                        n_final = 1'b0;
                    end
                end
            end
            default: n_state = F_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pad_first <= 1'b0;
        else          r_pad_first <= n_pad_first;
    end
    always_comb begin
        n_pad_first = r_pad_first;
        if (r_state == F_LOAD && acc && i_byte_valid && r_cnt == 6'd63)
            n_pad_first = 1'b1;
        else if (r_state == F_PAD)
            n_pad_first = 1'b0;
    end
endmodule

@@ hdl/sha_core.sv @@
// Back end: 64-round SHA-256 compression, one round per cycle, and digest output.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_core import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_blk_valid,
    output logic        o_blk_stall,
    input  t_blk        i_blk,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    t_bstate     r_state, n_state;
    logic [31:0] r_h [0:7];
    logic [31:0] r_v [0:7];
    logic [31:0] r_w [0:15];
    logic [5:0]  r_rnd;
    logic [2:0]  r_idx;
    logic        r_fin;
    logic [31:0] w2, w15, s0, s1, wnew, wi, e, a, t1, t2, ch, mj;

    assign o_blk_stall = (r_state != B_IDLE);
    assign o_valid       = (r_state == B_OUT);
    assign o_digest_word = r_h[r_idx];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == 3'd7);

    always_comb begin
        w2   = r_w[14];
        w15  = r_w[1];
        s1   = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        s0   = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        wnew = s1 + r_w[9] + s0 + r_w[0];
        wi   = r_w[0];
        e    = r_v[4];
        a    = r_v[0];
        ch   = (e & r_v[5]) ^ (~e & r_v[6]);
        mj   = (a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1   = r_v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ch + K_TABLE[r_rnd] + wi;
        t2   = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + mj;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (i_blk_valid) n_state = B_ROUND;
            B_ROUND: if (r_rnd == 6'd63) n_state = B_ADD;
            B_ADD:   n_state = r_fin ? B_OUT : B_IDLE;
            B_OUT:   if (!i_stall && r_idx == 3'd7) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_rnd   <= '0;
            r_idx   <= '0;
            r_fin   <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= H_INIT[i];
        end else begin
            r_state <= n_state;
            case (r_state)
                B_IDLE: begin
                    if (i_blk_valid) begin
                        r_fin <= i_blk.fin;
                        r_rnd <= '0;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                        for (int i = 0; i < 16; i++)
                            r_w[i] <= i_blk.blk[511 - 32 * i -: 32];
                    end
                end
                B_ROUND: begin
                    // window shifts so that w[0] is always the current round's word
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                    r_w[15] <= wnew;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_rnd  <= r_rnd + 6'd1;
                end
                B_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_idx <= '0;
                end
                B_OUT: begin
                    if (!i_stall) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7)
                            for (int i = 0; i < 8; i++) r_h[i] <= H_INIT[i];
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

@@ hdl/sha256_message_hasher.sv @@
// SHA-256 byte-stream hasher: at most one byte per accepted transaction.
// A compression runs 64 rounds in the core, then adds the result into the hash.
// The front accepts one byte per cycle while loading a block; after a full block
// or the end of a message it stalls until the core takes the block, which is
// longer while the core is still compressing or the digest is held off.
// Reset (synchronous, active low) restores the initial hash and clears counts.
`timescale 1ns / 1ps
module sha256_message_hasher import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    logic blk_valid, blk_stall;
    t_blk blk;

    sha_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data_byte, .i_byte_valid,
        .i_end_of_message, .o_blk_valid(blk_valid), .i_blk_stall(blk_stall),
        .o_blk(blk)
    );

    sha_core u_core (
        .i_clk, .i_rst_n, .i_blk_valid(blk_valid), .o_blk_stall(blk_stall),
        .i_blk(blk), .o_valid, .i_stall, .o_digest_word, .o_word_index,
        .o_last_word
    );
endmodule

@@ tb/sha256_message_hasher_test.sv @@
// Testbench for sha256_message_hasher: byte stream in, eight digest words out.
// Digests are predicted in-bench and compared per word; depends on sha_pkg.
`timescale 1ns / 1ps
module sha256_message_hasher_test;
    import sha_pkg::*;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_byte_valid;
    logic        i_end_of_message;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    sha256_message_hasher u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data_byte(i_data_byte), .i_byte_valid(i_byte_valid),
        .i_end_of_message(i_end_of_message), .o_valid(o_valid), .i_stall(i_stall),
        .o_digest_word(o_digest_word), .o_word_index(o_word_index),
        .o_last_word(o_last_word)
    );

    // predictor state
    logic [31:0] hash_state [0:7];
    logic [31:0] msg_words [0:15];
    logic [5:0]  fill_count;
    logic [63:0] bit_count;
    t_digest_out digest_queue [$];

    int  fail_count;
    int  cycle_count;
    bit  rx_idle_en;
    int  hold_cycles;
    bit  tx_idle_en;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic restart_hash();
        for (int i = 0; i < 8; i++) hash_state[i] = H_INIT[i];
        for (int i = 0; i < 16; i++) msg_words[i] = '0;
        fill_count = '0;
        bit_count = '0;
    endtask

    task automatic load_byte(logic [5:0] pos, logic [7:0] b);
        int sh;
        sh = (3 - pos[1:0]) * 8;
        msg_words[pos[5:2]] = (msg_words[pos[5:2]] & ~(32'hff << sh)) | (32'(b) << sh);
    endtask

    task automatic compress_words();
        logic [31:0] v [0:7];
        logic [31:0] w [0:15];
        logic [31:0] wi, s0, s1, t1, t2;
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int i = 0; i < 16; i++) w[i] = msg_words[i];
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                wi = w[r];
            end else begin
                s1 = ror32(w[(r-2)%16], 17) ^ ror32(w[(r-2)%16], 19) ^ (w[(r-2)%16] >> 10);
                s0 = ror32(w[(r-15)%16], 7) ^ ror32(w[(r-15)%16], 18) ^ (w[(r-15)%16] >> 3);
                wi = s1 + w[(r-7)%16] + s0 + w[r%16];
                w[r%16] = wi;
            end
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[r] + wi;
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 16; i++) msg_words[i] = w[i];
        for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
    endtask

    task automatic predict_digest(logic [7:0] b, logic bv, logic eom);
        t_digest_out d;
        if (bv) begin
            load_byte(fill_count, b);
            bit_count = bit_count + 64'd8;
            fill_count = fill_count + 6'd1;
            if (fill_count == 6'd0) compress_words();
        end
        if (!eom) return;
        load_byte(fill_count, PAD_BYTE);
        if (fill_count == 6'd63) begin
            compress_words();
            fill_count = '0;
        end else begin
            fill_count = fill_count + 6'd1;
            if (fill_count > LEN_POS) begin
                while (fill_count != 6'd0) begin
                    load_byte(fill_count, 8'h00);
                    fill_count = fill_count + 6'd1;
                end
                compress_words();
            end
        end
        while (fill_count < LEN_POS) begin
            load_byte(fill_count, 8'h00);
            fill_count = fill_count + 6'd1;
        end
        msg_words[14] = bit_count[63:32];
        msg_words[15] = bit_count[31:0];
        compress_words();
        for (int i = 0; i < 8; i++) begin
            d.digest_word = hash_state[i];
            d.word_index = 3'(i);
            d.last_word = (i == 7);
            digest_queue = {digest_queue, d};
        end
        restart_hash();
    endtask

    // one transaction; optional random gap before it. Valid stays high after
    // acceptance: the caller either drives the next transaction or drops it.
    task automatic send_byte(logic [7:0] b, logic bv, logic eom);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_byte_valid <= bv;
        i_end_of_message <= eom;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_digest(b, bv, eom);
    endtask

    task automatic send_message(int len, bit noise);
        bit close_on_byte;
        close_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++) begin
            if (noise && $urandom_range(0, 5) == 0)
                send_byte(8'($urandom), 1'b0, 1'b0);
            send_byte(8'($urandom), 1'b1, close_on_byte && (i == len - 1));
        end
        // otherwise close on a transaction without a byte
        if (!close_on_byte)
            send_byte(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (digest_queue.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_byte(8'h00, 1'b0, 1'b1);                     // empty message
        send_byte(8'hff, 1'b0, 1'b1);                     // ignored data with eom
        send_byte(8'h61, 1'b1, 1'b0);
        send_byte(8'h62, 1'b1, 1'b0);
        send_byte(8'h63, 1'b1, 1'b1);                     // "abc", byte with eom
        send_byte(8'hff, 1'b1, 1'b0);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'haa, 1'b0, 1'b0);                     // no byte, not eom
        send_byte(8'h55, 1'b1, 1'b1);
        drain_results();
    endtask

    // padding boundaries: 55, 56, 63, 64 byte messages
    task automatic test_pad_edges();
        int lens [4] = '{55, 56, 63, 64};
        foreach (lens[k]) send_message(lens[k], 1'b0);
        drain_results();
    endtask

    task automatic test_backpressure();
        // receiver holds off while the sender keeps offering; the second and
        // third messages back up behind the held digest
        hold_cycles = 600;
        send_message(12, 1'b0);
        send_message(3, 1'b0);
        send_message(5, 1'b0);
        i_valid <= 1'b0;
        wait (hold_cycles == 0);
        drain_results();
    endtask

    task automatic test_random(int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(0, 20);
            if (len + 1 > n_items - sent) len = n_items - sent - 1;
            send_message(len, 1'b1);
            sent += len + 1;
        end
        drain_results();
    endtask

    // receiver stall
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_digest_out exp_d;
        if (i_rst_n && o_valid && !i_stall) begin
            if (digest_queue.size() == 0) begin
                $error("unexpected digest word %h", o_digest_word);
                fail_count++;
            end else begin
                exp_d = digest_queue.pop_front();
                if (o_digest_word !== exp_d.digest_word) begin
                    $error("digest_word expected %h actual %h",
                           exp_d.digest_word, o_digest_word);
                    fail_count++;
                end
                if (o_word_index !== exp_d.word_index) begin
                    $error("word_index expected %0d actual %0d",
                           exp_d.word_index, o_word_index);
                    fail_count++;
                end
                if (o_last_word !== exp_d.last_word) begin
                    $error("last_word expected %0d actual %0d",
                           exp_d.last_word, o_last_word);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        fail_count = 0;
        cycle_count = 0;
        hold_cycles = 0;
        rx_idle_en = 1'b0;
        tx_idle_en = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data_byte = '0;
        i_byte_valid = 1'b0;
        i_end_of_message = 1'b0;
        restart_hash();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        rx_idle_en = 1'b1;
        tx_idle_en = 1'b1;
        test_pad_edges();
        test_backpressure();
        rx_idle_en = 1'b0;
        tx_idle_en = 1'b0;
        test_random(12);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/sha_pkg.sv
hdl/sha_front.sv
hdl/sha_core.sv
hdl/sha256_message_hasher.sv
tb/sha256_message_hasher_test.sv
